[rtl/leb_node_attribute_decode_unit_defines.svh]
// Assertion macros shared by the checker of the bisection attribute decoder.
`ifndef LEB_NODE_ATTRIBUTE_DECODE_UNIT_DEFINES_SVH
`define LEB_NODE_ATTRIBUTE_DECODE_UNIT_DEFINES_SVH

// Checked on every rising edge of clk while rst_n is high.
`define LEB_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every rising edge of clk, reset included.
`define LEB_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[rtl/lebdec_pkg.sv]
// Package with the shared widths and the pipeline control type of the decoder.
`default_nettype none

package lebdec_pkg;

    // Fixed port widths.
    localparam int ID_W    = 31;
    localparam int DEPTH_W = 5;
    localparam int FIELD_W = 32;
    // Width used to compare a depth against a level number (values up to 127 fit).
    localparam int CMP_W   = 7;

    // Control that travels with each beat down the pipeline.
    typedef struct packed {
        logic               valid;
        logic               last;
        logic [DEPTH_W-1:0] depth;
        logic [ID_W-1:0]    id;
    } ctl_t;

endpackage

`default_nettype wire

[rtl/lebdec_stage.sv]
// One bisection level of the decoder pipeline: select and average, then register.
`default_nettype none

module lebdec_stage #(
    parameter int WW    = 62,
    parameter int LEVEL = 1
) (
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire lebdec_pkg::ctl_t ctl_in,
    input  wire  [WW-1:0]       va_in,
    input  wire  [WW-1:0]       vb_in,
    input  wire  [WW-1:0]       vc_in,
    output lebdec_pkg::ctl_t    ctl_out,
    output logic [WW-1:0]       va_out,
    output logic [WW-1:0]       vb_out,
    output logic [WW-1:0]       vc_out
);

    lebdec_pkg::ctl_t ctl_reg;
    logic [WW-1:0]    va_reg, vb_reg, vc_reg;
    logic [WW-1:0]    va_next, vb_next, vc_next;
    logic [WW:0]      sum;
    logic [WW-1:0]    mid;
    logic             active;
    logic             dir;

    // The level is applied only when the node is at least this deep.
    assign active = (lebdec_pkg::CMP_W'(ctl_in.depth) >= lebdec_pkg::CMP_W'(LEVEL));

    generate
        if (LEVEL <= lebdec_pkg::ID_W) begin : g_bit
            assign dir = ctl_in.id[LEVEL-1];
        end else begin : g_nobit
            // A depth field cannot reach this level, so the stage only passes data.
            assign dir = 1'b0;
        end
    endgenerate

    // The guard bits keep the average exact.
    assign sum = {1'b0, va_in} + {1'b0, vc_in};
    assign mid = sum[WW:1];

    always_comb
    begin
        va_next = va_in;
        vb_next = vb_in;
        vc_next = vc_in;
        if (active)
        begin
            if (dir)
            begin
                va_next = vb_in;
                vb_next = mid;
            end
            else
            begin
                vc_next = vb_in;
                vb_next = mid;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ctl_reg <= '0;
        else
            ctl_reg <= ctl_in;
    end

    always_ff @(posedge clk)
    begin
        va_reg <= va_next;
        vb_reg <= vb_next;
        vc_reg <= vc_next;
    end

    assign ctl_out = ctl_reg;
    assign va_out  = va_reg;
    assign vb_out  = vb_reg;
    assign vc_out  = vc_reg;

endmodule

`default_nettype wire

[rtl/lebdec_round.sv]
// Output stage of the decoder: odd-depth swap, rounding and the result registers.
`default_nettype none

module lebdec_round #(
    parameter int ATTR_WIDTH = 32,
    parameter int MAX_DEPTH  = 30
) (
    input  wire                                clk,
    input  wire                                rst_n,
    input  wire lebdec_pkg::ctl_t              ctl_in,
    input  wire  [ATTR_WIDTH+MAX_DEPTH-1:0]    va_in,
    input  wire  [ATTR_WIDTH+MAX_DEPTH-1:0]    vb_in,
    input  wire  [ATTR_WIDTH+MAX_DEPTH-1:0]    vc_in,
    output logic                               out_valid,
    output logic [lebdec_pkg::FIELD_W-1:0]     out_a,
    output logic [lebdec_pkg::FIELD_W-1:0]     out_b,
    output logic [lebdec_pkg::FIELD_W-1:0]     out_c,
    output logic                               last_out
);

    localparam int WW = ATTR_WIDTH + MAX_DEPTH;
    localparam logic [WW-1:0] HALF = WW'(1) << (MAX_DEPTH - 1);

    logic [WW-1:0]                  lane    [3];
    logic [WW-1:0]                  rsum    [3];
    logic [ATTR_WIDTH-1:0]          flip    [3];
    logic [lebdec_pkg::FIELD_W-1:0] fld     [3];

    logic                           valid_reg;
    logic                           last_reg;
    logic [lebdec_pkg::FIELD_W-1:0] a_reg, b_reg, c_reg;

    // An odd depth swaps the first and third corners.
    assign lane[0] = ctl_in.depth[0] ? vc_in : va_in;
    assign lane[1] = vb_in;
    assign lane[2] = ctl_in.depth[0] ? va_in : vc_in;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            // Round half up; the carry out of the top bit is dropped on purpose.
            rsum[i] = lane[i] + HALF;
            flip[i] = {~rsum[i][WW-1], rsum[i][WW-2:MAX_DEPTH]};
            fld[i]  = lebdec_pkg::FIELD_W'($signed(flip[i]));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= ctl_in.valid;
    end

    always_ff @(posedge clk)
    begin
        last_reg <= ctl_in.last;
        a_reg    <= fld[0];
        b_reg    <= fld[1];
        c_reg    <= fld[2];
    end

    assign out_valid = valid_reg;
    assign last_out  = last_reg;
    assign out_a     = a_reg;
    assign out_b     = b_reg;
    assign out_c     = c_reg;

endmodule

`default_nettype wire

[rtl/leb_node_attribute_decode_unit.sv]
// Top level of the longest-edge-bisection attribute decoder.
`default_nettype none

// The decoder carries one attribute triple from a bisection-tree root down to
// the node named by node_index and node_depth.  It is a fixed pipeline with one
// stage per tree level: a beat is taken on every clock edge at which start is
// high, and busy never rises, so one item per cycle is sustained.  Each beat
// produces exactly one result beat, marked by out_valid for a single cycle,
// after it has passed one input register, MAX_DEPTH level stages and one
// rounding and output register.  The latency is the same for every
// depth; shallower nodes simply pass through the levels they do not need.  The
// receiver must take every result beat in the cycle it appears, since nothing
// in the block can hold a result back.  Depths above MAX_DEPTH are treated as
// MAX_DEPTH, id bits at or above the depth are ignored, and each result is
// rounded half up from MAX_DEPTH guard bits, which keeps every average exact.
module leb_node_attribute_decode_unit #(
    parameter int MAX_DEPTH  = 30,
    parameter int ATTR_WIDTH = 32
) (
    input  wire                                 clk,
    input  wire                                 rst_n,
    input  wire                                 start,
    output logic                                busy,
    input  wire  [lebdec_pkg::ID_W-1:0]         node_index,
    input  wire  [lebdec_pkg::DEPTH_W-1:0]      node_depth,
    input  wire  signed [lebdec_pkg::FIELD_W-1:0] attr_a,
    input  wire  signed [lebdec_pkg::FIELD_W-1:0] attr_b,
    input  wire  signed [lebdec_pkg::FIELD_W-1:0] attr_c,
    input  wire                                 last_in_node,
    output logic                                out_valid,
    output logic signed [lebdec_pkg::FIELD_W-1:0] out_a,
    output logic signed [lebdec_pkg::FIELD_W-1:0] out_b,
    output logic signed [lebdec_pkg::FIELD_W-1:0] out_c,
    output logic                                last_out
);

    // Working width: the attribute plus one guard bit per possible level.
    localparam int WW = ATTR_WIDTH + MAX_DEPTH;
    localparam int XW = (ATTR_WIDTH > lebdec_pkg::FIELD_W) ? ATTR_WIDTH
                                                           : lebdec_pkg::FIELD_W;

    // Pipeline taps: index 0 is the input register, index MAX_DEPTH the last level.
    lebdec_pkg::ctl_t ctl_s [MAX_DEPTH+1];
    logic [WW-1:0]    va_s  [MAX_DEPTH+1];
    logic [WW-1:0]    vb_s  [MAX_DEPTH+1];
    logic [WW-1:0]    vc_s  [MAX_DEPTH+1];

    lebdec_pkg::ctl_t ctl_reg, ctl_next;
    logic [WW-1:0]    va_reg, vb_reg, vc_reg;
    logic [WW-1:0]    va_next, vb_next, vc_next;
    logic [XW-1:0]    a_x, b_x, c_x;
    logic [lebdec_pkg::DEPTH_W-1:0] depth_sat;
    logic [lebdec_pkg::FIELD_W-1:0] res_a, res_b, res_c;

    // The pipeline never stalls, so a beat is always welcome.
    assign busy = 1'b0;

    // Depths beyond the deepest handled level saturate; the saturated value
    // also decides the final swap.
    assign depth_sat = (lebdec_pkg::CMP_W'(node_depth) > lebdec_pkg::CMP_W'(MAX_DEPTH))
                     ? lebdec_pkg::DEPTH_W'(MAX_DEPTH) : node_depth;

    // Only the low ATTR_WIDTH bits of an attribute port are meaningful.
    assign a_x = XW'($unsigned(attr_a));
    assign b_x = XW'($unsigned(attr_b));
    assign c_x = XW'($unsigned(attr_c));

    // Flipping the sign bit offsets each value to unsigned, and the guard bits
    // go below it so that every later average is exact.
    always_comb
    begin
        ctl_next.valid = start;
        ctl_next.last  = last_in_node;
        ctl_next.depth = depth_sat;
        ctl_next.id    = node_index;
        va_next = {~a_x[ATTR_WIDTH-1], a_x[ATTR_WIDTH-2:0], {MAX_DEPTH{1'b0}}};
        vb_next = {~b_x[ATTR_WIDTH-1], b_x[ATTR_WIDTH-2:0], {MAX_DEPTH{1'b0}}};
        vc_next = {~c_x[ATTR_WIDTH-1], c_x[ATTR_WIDTH-2:0], {MAX_DEPTH{1'b0}}};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ctl_reg <= '0;
        else
            ctl_reg <= ctl_next;
    end

    always_ff @(posedge clk)
    begin
        va_reg <= va_next;
        vb_reg <= vb_next;
        vc_reg <= vc_next;
    end

    assign ctl_s[0] = ctl_reg;
    assign va_s[0]  = va_reg;
    assign vb_s[0]  = vb_reg;
    assign vc_s[0]  = vc_reg;

    // The id is walked from its highest used bit down, so the first stage
    // handles level MAX_DEPTH and the last stage handles level one.
    generate
        for (genvar s = 0; s < MAX_DEPTH; s++) begin : g_level
            lebdec_stage #(
                .WW    (WW),
                .LEVEL (MAX_DEPTH - s)
            ) u_stage (
                .clk     (clk),
                .rst_n   (rst_n),
                .ctl_in  (ctl_s[s]),
                .va_in   (va_s[s]),
                .vb_in   (vb_s[s]),
                .vc_in   (vc_s[s]),
                .ctl_out (ctl_s[s+1]),
                .va_out  (va_s[s+1]),
                .vb_out  (vb_s[s+1]),
                .vc_out  (vc_s[s+1])
            );
        end
    endgenerate

    // Swap for odd depth, round away the guard bits and register the result.
    lebdec_round #(
        .ATTR_WIDTH (ATTR_WIDTH),
        .MAX_DEPTH  (MAX_DEPTH)
    ) u_round (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl_in    (ctl_s[MAX_DEPTH]),
        .va_in     (va_s[MAX_DEPTH]),
        .vb_in     (vb_s[MAX_DEPTH]),
        .vc_in     (vc_s[MAX_DEPTH]),
        .out_valid (out_valid),
        .out_a     (res_a),
        .out_b     (res_b),
        .out_c     (res_c),
        .last_out  (last_out)
    );

    assign out_a = $signed(res_a);
    assign out_b = $signed(res_b);
    assign out_c = $signed(res_c);

endmodule

`default_nettype wire

[rtl/lebdec_checker.sv]
// Port-level checker of the decoder and the bind that attaches it.
`default_nettype none
`include "leb_node_attribute_decode_unit_defines.svh"

module lebdec_checker #(
    parameter int LATENCY = 32
) (
    input wire clk,
    input wire rst_n,
    input wire start,
    input wire busy,
    input wire last_in_node,
    input wire out_valid,
    input wire last_out
);

    property p_last_follows;
        start |-> ##LATENCY (last_out == $past(last_in_node, LATENCY));
    endproperty

    // No result beat may appear while the block is held in reset.
    `LEB_ASSERT_ALWAYS(a_no_result_in_reset, !rst_n |-> !out_valid, "result beat during reset")

    // The pipeline takes a beat every cycle.
    `LEB_ASSERT(a_never_busy, !busy, "busy raised")

    // Every taken beat comes out after the fixed latency.
    `LEB_ASSERT(a_fixed_latency, start |-> ##LATENCY out_valid, "result beat missing")

    // The end-of-node mark travels with its own beat.
    `LEB_ASSERT(a_last_follows, p_last_follows, "last_out mismatch")

endmodule

bind leb_node_attribute_decode_unit lebdec_checker #(
    .LATENCY (MAX_DEPTH + 2)
) u_lebdec_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .last_in_node (last_in_node),
    .out_valid    (out_valid),
    .last_out     (last_out)
);

`default_nettype wire

[dv/leb_node_attribute_decode_unit_tb.sv]
// Self-checking testbench for the longest-edge-bisection attribute decoder.
`default_nettype none

module leb_node_attribute_decode_unit_tb;

    localparam int ID_W    = lebdec_pkg::ID_W;
    localparam int DEPTH_W = lebdec_pkg::DEPTH_W;
    localparam int FIELD_W = lebdec_pkg::FIELD_W;

    // The block is built with its default sizes, and the predictor uses the same ones.
    localparam int LEB_DEPTH = 30;
    localparam int LEB_WIDTH = 32;
    // Idle time after the last result has drained, before the run is closed.
    localparam int DRAIN_CYCLES = LEB_DEPTH + 8;
    // Random beats per idle phase. There are four phases, so about 900 beats in all.
    localparam int PHASE_BEATS = 225;

    // One decoded triple, as the block should present it on its result ports.
    typedef struct packed {
        logic signed [FIELD_W-1:0] a;
        logic signed [FIELD_W-1:0] b;
        logic signed [FIELD_W-1:0] c;
        logic                      last;
    } corner_triple_t;

    // The scoreboard predicts the decoded triple for every accepted beat. It keeps
    // these in arrival order, because the pipeline never reorders beats. It then
    // matches each result beat against the oldest prediction.
    class leb_scoreboard;
        corner_triple_t triples_due[$];
        int             errors;

        function new();
            errors = 0;
        endfunction

        // A signed attribute is moved to an offset, unsigned form with guard bits.
        // In that form every average is exact.
        function automatic logic [63:0] widen(logic [FIELD_W-1:0] raw);
            logic [63:0] w;
            w = {32'd0, raw ^ (32'd1 << (LEB_WIDTH - 1))};
            return w << LEB_DEPTH;
        endfunction

        // Round half up, drop the guard bits and take the offset out again.
        function automatic logic [FIELD_W-1:0] narrow(logic [63:0] x);
            logic [63:0] r;
            r = (x + (64'd1 << (LEB_DEPTH - 1))) >> LEB_DEPTH;
            return r[FIELD_W-1:0] ^ (32'd1 << (LEB_WIDTH - 1));
        endfunction

        function automatic corner_triple_t decode_node(
            logic [ID_W-1:0] idx, logic [DEPTH_W-1:0] depth,
            logic [FIELD_W-1:0] a, logic [FIELD_W-1:0] b, logic [FIELD_W-1:0] c,
            logic last);
            corner_triple_t res;
            logic [63:0]    v0, v1, v2, mid, t;
            int             d;
            int             lvl;
            d = (depth > LEB_DEPTH) ? LEB_DEPTH : int'(depth);
            v0 = widen(a);
            v1 = widen(b);
            v2 = widen(c);
            // One bisection step per id bit, from the top level down to bit 0.
            for (lvl = d; lvl > 0; lvl--)
            begin
                mid = (v0 + v2) >> 1;
                if (idx[lvl-1])
                begin
                    v0 = v1;
                    v1 = mid;
                end
                else
                begin
                    v2 = v1;
                    v1 = mid;
                end
            end
            // The winding flips at odd depth. The saturated depth decides it.
            if (d % 2 == 1)
            begin
                t  = v0;
                v0 = v2;
                v2 = t;
            end
            res.a    = narrow(v0);
            res.b    = narrow(v1);
            res.c    = narrow(v2);
            res.last = last;
            return res;
        endfunction

        function void note_beat(logic [ID_W-1:0] idx, logic [DEPTH_W-1:0] depth,
                                logic [FIELD_W-1:0] a, logic [FIELD_W-1:0] b,
                                logic [FIELD_W-1:0] c, logic last);
            triples_due.push_back(decode_node(idx, depth, a, b, c, last));
        endfunction

        function void check_result(corner_triple_t got);
            corner_triple_t want;
            if (triples_due.size() == 0)
            begin
                $error("result beat with no beat outstanding: a=%h b=%h c=%h last=%b",
                       got.a, got.b, got.c, got.last);
                errors++;
                return;
            end
            want = triples_due.pop_front();
            if (got.a !== want.a)
            begin
                $error("out_a: expected %h, got %h", want.a, got.a);
                errors++;
            end
            if (got.b !== want.b)
            begin
                $error("out_b: expected %h, got %h", want.b, got.b);
                errors++;
            end
            if (got.c !== want.c)
            begin
                $error("out_c: expected %h, got %h", want.c, got.c);
                errors++;
            end
            if (got.last !== want.last)
            begin
                $error("last_out: expected %b, got %b", want.last, got.last);
                errors++;
            end
        endfunction

        function int pending();
            return triples_due.size();
        endfunction
    endclass

    logic clk = 1'b0;
    // Reset falls at time zero, once every process is waiting, so the block's
    // registers are cleared before the first clock edge.
    logic rst_n = 1'b1;

    // Every input starts at a known value. After that, the inputs change only
    // through nonblocking assignments at a rising edge.
    logic                      start        = 1'b0;
    logic [ID_W-1:0]           node_index   = '0;
    logic [DEPTH_W-1:0]        node_depth   = '0;
    logic signed [FIELD_W-1:0] attr_a       = '0;
    logic signed [FIELD_W-1:0] attr_b       = '0;
    logic signed [FIELD_W-1:0] attr_c       = '0;
    logic                      last_in_node = 1'b0;

    logic                      busy;
    logic                      out_valid;
    logic signed [FIELD_W-1:0] out_a;
    logic signed [FIELD_W-1:0] out_b;
    logic signed [FIELD_W-1:0] out_c;
    logic                      last_out;

    leb_scoreboard triples = new();

    leb_node_attribute_decode_unit #(
        .MAX_DEPTH  (LEB_DEPTH),
        .ATTR_WIDTH (LEB_WIDTH)
    ) u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .node_index   (node_index),
        .node_depth   (node_depth),
        .attr_a       (attr_a),
        .attr_b       (attr_b),
        .attr_c       (attr_c),
        .last_in_node (last_in_node),
        .out_valid    (out_valid),
        .out_a        (out_a),
        .out_b        (out_b),
        .out_c        (out_c),
        .last_out     (last_out)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Watch both sides at each rising edge. The driver's inputs and the block's
    // outputs change only in the nonblocking region. This block therefore always
    // sees the values from before the edge, and those are the values the block
    // acts on. An input beat is taken when start is high and busy is low. A
    // result beat is taken whenever out_valid is high, because the block cannot
    // be held off.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (start && !busy)
                triples.note_beat(node_index, node_depth, attr_a, attr_b, attr_c,
                                  last_in_node);
            if (out_valid)
                triples.check_result('{a: out_a, b: out_b, c: out_c, last: last_out});
        end
    end

    // Present one beat and hold it until the block takes it. Start is left high,
    // so a following beat can go out on the very next cycle.
    task automatic send_beat(logic [ID_W-1:0] idx, logic [DEPTH_W-1:0] depth,
                             logic [FIELD_W-1:0] a, logic [FIELD_W-1:0] b,
                             logic [FIELD_W-1:0] c, logic last);
        start        <= 1'b1;
        node_index   <= idx;
        node_depth   <= depth;
        attr_a       <= a;
        attr_b       <= b;
        attr_c       <= c;
        last_in_node <= last;
        do
            @(posedge clk);
        while (busy);
    endtask

    // Idle the sender for a random number of cycles. The chance of each further
    // idle cycle is pct in a hundred. While idle, the payload ports carry noise.
    // The block must ignore it, and it is not counted as a beat.
    task automatic idle_gap(int pct);
        while ($urandom_range(0, 99) < pct)
        begin
            start        <= 1'b0;
            node_index   <= ID_W'($urandom);
            node_depth   <= DEPTH_W'($urandom);
            attr_a       <= $urandom;
            attr_b       <= $urandom;
            attr_c       <= $urandom;
            last_in_node <= 1'($urandom);
            @(posedge clk);
        end
    endtask

    // Stop sending and wait until every outstanding beat has come back.
    task automatic drain_results();
        start <= 1'b0;
        @(posedge clk);
        while (triples.pending() != 0)
            @(posedge clk);
    endtask

    // Attribute values lean toward the extremes and small magnitudes. Those are
    // where offset and rounding mistakes show up.
    function automatic logic [FIELD_W-1:0] pick_attr();
        case ($urandom_range(0, 5))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return FIELD_W'($urandom_range(0, 15)) - 32'd8;
            default: return $urandom;
        endcase
    endfunction

    task automatic send_random_beat();
        logic [DEPTH_W-1:0] depth;
        // Most beats use a legal depth. Some use depth 31, which must saturate.
        depth = ($urandom_range(0, 9) == 0) ? 5'd31 : DEPTH_W'($urandom_range(0, 30));
        send_beat(ID_W'($urandom), depth, pick_attr(), pick_attr(), pick_attr(),
                  1'($urandom));
    endtask

    initial
    begin
        int pct_per_phase[4];
        int ph;
        int n;
        rst_n <= 1'b0;
        // Sender idle rates for the phases: none, heavy, none, light. The result
        // side cannot stall, so the two phases meant to stall the receiver reduce
        // to their sender part.
        pct_per_phase = '{0, 78, 0, 17};

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed beats.
        // At depth zero the triple passes through unchanged, including at the extremes.
        send_beat(31'h1234_5678, 5'd0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h1234_5678, 1'b1);
        send_beat(31'h7FFF_FFFF, 5'd0, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 1'b0);
        // Single steps down each child. The average of 0 and 1 lands on an exact
        // half, which must round up.
        send_beat(31'h0, 5'd1, 32'h0000_0000, 32'h0001_0000, 32'h0000_0001, 1'b0);
        send_beat(31'h1, 5'd1, 32'h0000_0000, 32'h0001_0000, 32'h0000_0001, 1'b1);
        send_beat(31'h0, 5'd1, 32'hFFFF_FFFF, 32'h0000_0000, 32'h0000_0000, 1'b0);
        // Full depth, with every id bit set and then every id bit clear.
        send_beat(31'h7FFF_FFFF, 5'd30, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                  1'b1);
        send_beat(31'h0, 5'd30, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 1'b0);
        // Depth 31 saturates to 30. The even saturated depth means no final swap.
        send_beat(31'h2AAA_AAAA, 5'd31, 32'h0001_0000, 32'hFFFF_0000, 32'h7FFF_0000, 1'b1);
        send_beat(31'h5555_5555, 5'd31, 32'h8000_0001, 32'h0000_0003, 32'h7FFF_FFFE, 1'b0);
        // The two beats below differ only in id bits above the depth. Those bits
        // are ignored, so both must decode the same.
        send_beat(31'h7FFF_FFF8, 5'd3, 32'h0003_0000, 32'h0000_0001, 32'hFFFD_0000, 1'b0);
        send_beat(31'h0000_0000, 5'd3, 32'h0003_0000, 32'h0000_0001, 32'hFFFD_0000, 1'b1);
        send_beat(31'h2, 5'd2, 32'hFFFF_FFFF, 32'h0000_0001, 32'hFFFF_FFFF, 1'b0);
        send_beat(31'h0001_5A5A, 5'd17, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b1);
        send_beat(ID_W'($urandom), 5'd30, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                  1'b0);
        send_beat(31'h0000_0005, 5'd5, 32'h0000_0001, 32'h0000_0002, 32'h0000_0004, 1'b1);
        drain_results();

        // Random beats, one idle phase after another. After the heavy-idle phase,
        // the sender stops until the block is empty, then carries on back to back.
        for (ph = 0; ph < 4; ph++)
        begin
            for (n = 0; n < PHASE_BEATS; n++)
            begin
                send_random_beat();
                idle_gap(pct_per_phase[ph]);
            end
            if (ph == 1)
                drain_results();
        end

        drain_results();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (triples.errors == 0 && triples.pending() == 0)
            $display("leb_node_attribute_decode_unit_tb: done, clean");
        else
            $display("leb_node_attribute_decode_unit_tb: done, errors");
        $finish;
    end

    // Watchdog. It closes a run that never finishes and reports it with errors.
    initial
    begin
        #400000;
        $display("leb_node_attribute_decode_unit_tb: done, errors");
        $finish;
    end

endmodule

`default_nettype wire

[leb_node_attribute_decode_unit.f]
+incdir+rtl
rtl/lebdec_pkg.sv
rtl/lebdec_stage.sv
rtl/lebdec_round.sv
rtl/leb_node_attribute_decode_unit.sv
rtl/lebdec_checker.sv
dv/leb_node_attribute_decode_unit_tb.sv
